// ----- src/durs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package durs_pkg;

  // Width of the timing counter: ticks_per_us (8 bits) times microseconds (16 bits).
  localparam int CNT_W   = 24;
  localparam int RD_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // Sequencer phase codes.
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_PULSE       = 3'd1;
  localparam logic [2:0] PH_WAIT        = 3'd2;
  localparam logic [2:0] PH_TIMING      = 3'd3;
  localparam logic [2:0] PH_SETTLE      = 3'd4;
  localparam logic [2:0] PH_SETTLE_FIRE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_US     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_US    = 8'd3;

  // Configuration reset values.
  localparam logic [7:0]  TICKS_PER_US_RST = 8'd50;
  localparam logic [7:0]  PULSE_US_RST     = 8'd8;
  localparam logic [15:0] TIMEOUT_US_RST   = 16'd36000;
  localparam logic [15:0] SETTLE_US_RST    = 16'd10000;

  localparam logic [RD_W-1:0] RD_TIMEOUT = {RD_W{1'b1}};

  typedef struct packed {
    logic start_request;
    logic echo_first;
    logic echo_second;
  } durs_in_t;

  typedef struct packed {
    logic            trigger_first;
    logic            trigger_second;
    logic            busy_res;
    logic            pair_valid;
    logic [RD_W-1:0] reading_first;
    logic [RD_W-1:0] reading_second;
  } durs_out_t;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [7:0]  pulse_us;
    logic [15:0] timeout_us;
    logic [15:0] settle_us;
  } durs_cfg_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic             sel;
    logic [CNT_W-1:0] cnt;
    logic             run;
    logic [1:0]       prev_echo;
    logic [1:0]       trig;
    logic [RD_W-1:0]  rd0;
    logic [RD_W-1:0]  rd1;
  } durs_state_t;

endpackage

`default_nettype wire

// ----- src/durs_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module durs_step
  import durs_pkg::*;
(
  input  wire durs_cfg_t   cfg,
  input  wire durs_state_t st,
  input  wire durs_in_t    item,
  output durs_state_t      st_nxt,
  output durs_out_t        res
);

  logic [CNT_W-1:0] pulse_ld;
  logic [CNT_W-1:0] timeout_ld;
  logic [CNT_W-1:0] settle_ld;

  // Counter loads in clock ticks.
  assign pulse_ld   = {16'd0, cfg.ticks_per_us} * {16'd0, cfg.pulse_us};
  assign timeout_ld = {16'd0, cfg.ticks_per_us} * {8'd0, cfg.timeout_us};
  assign settle_ld  = {16'd0, cfg.ticks_per_us} * {8'd0, cfg.settle_us};

  // One tick: counter, echo edge, expiry, then start request.
  always_comb begin
    logic [1:0] echo;
    logic       expire;
    logic       pair;
    logic       level;

    st_nxt = st;
    echo   = {item.echo_second, item.echo_first};
    expire = 1'b0;
    pair   = 1'b0;
    level  = st.sel ? echo[1] : echo[0];

    // The one-shot counter expires on its last tick.
    if (st.run) begin
      if (st.cnt <= CNT_W'(1)) begin
        st_nxt.cnt = '0;
        st_nxt.run = 1'b0;
        expire     = 1'b1;
      end else begin
        st_nxt.cnt = st.cnt - CNT_W'(1);
      end
    end

    // An edge on either echo pin; its load cancels a pending expiry.
    if (echo != st.prev_echo) begin
      if (level) begin
        st_nxt.phase = PH_TIMING;
        st_nxt.cnt   = timeout_ld;
      end else begin
        if (st.sel) begin
          st_nxt.rd1 = {{(RD_W-CNT_W){1'b0}}, st_nxt.cnt};
        end else begin
          st_nxt.rd0 = {{(RD_W-CNT_W){1'b0}}, st_nxt.cnt};
        end
        st_nxt.sel = ~st.sel;
        if (st.sel) begin
          st_nxt.phase = PH_SETTLE;
          pair         = 1'b1;
        end else begin
          st_nxt.phase = PH_SETTLE_FIRE;
        end
        st_nxt.cnt = settle_ld;
      end
      st_nxt.run = 1'b1;
      expire     = 1'b0;
    end
    st_nxt.prev_echo = echo;

    // Counter expiry, by phase.
    if (expire) begin
      case (st_nxt.phase)
        PH_PULSE: begin
          st_nxt.phase = PH_WAIT;
          st_nxt.trig  = 2'b00;
          st_nxt.cnt   = timeout_ld;
          st_nxt.run   = 1'b1;
        end
        PH_SETTLE: begin
          st_nxt.phase = PH_IDLE;
        end
        PH_SETTLE_FIRE: begin
          st_nxt.phase = PH_PULSE;
          st_nxt.trig  = st_nxt.sel ? 2'b10 : 2'b01;
          st_nxt.cnt   = pulse_ld;
          st_nxt.run   = 1'b1;
        end
        default: begin
          // No echo or an overlong echo: mark the reading as timed out.
          if (st_nxt.sel) begin
            st_nxt.rd1 = RD_TIMEOUT;
          end else begin
            st_nxt.rd0 = RD_TIMEOUT;
          end
          st_nxt.phase = PH_IDLE;
          if (st_nxt.sel) begin
            pair       = 1'b1;
            st_nxt.sel = 1'b0;
          end else begin
            st_nxt.sel   = 1'b1;
            st_nxt.phase = PH_PULSE;
            st_nxt.trig  = 2'b10;
            st_nxt.cnt   = pulse_ld;
            st_nxt.run   = 1'b1;
          end
        end
      endcase
    end

    // Start request is taken only when idle or settling.
    if (item.start_request) begin
      if (st_nxt.phase == PH_IDLE) begin
        st_nxt.phase = PH_PULSE;
        st_nxt.trig  = st_nxt.sel ? 2'b10 : 2'b01;
        st_nxt.cnt   = pulse_ld;
        st_nxt.run   = 1'b1;
      end else if (st_nxt.phase == PH_SETTLE) begin
        st_nxt.phase = PH_SETTLE_FIRE;
      end
    end

    res.trigger_first  = st_nxt.trig[0];
    res.trigger_second = st_nxt.trig[1];
    res.busy_res       = (st_nxt.phase != PH_IDLE) && (st_nxt.phase != PH_SETTLE);
    res.pair_valid     = pair;
    res.reading_first  = st_nxt.rd0;
    res.reading_second = st_nxt.rd1;
  end

endmodule

`default_nettype wire

// ----- src/dual_ultrasonic_ranger_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The result item for an input item is registered and is offered in the cycle after it is accepted.
// Throughput: one input item per cycle; the sequencer state advances in one pass per item.
// A waiting result does not block the next item unless the output side stalls.
// Reset (synchronous, active low) sets the phase to idle, clears counter, readings and
// triggers, and restores the configuration registers to their defaults.

module dual_ultrasonic_ranger_sequencer
  import durs_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire durs_in_t        in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output durs_out_t            out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DAT_W-1:0]  cfg_data
);

  durs_cfg_t   cfg_r;
  durs_state_t st_r;
  durs_state_t st_nxt;
  durs_out_t   res_nxt;
  durs_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us <= TICKS_PER_US_RST;
      cfg_r.pulse_us     <= PULSE_US_RST;
      cfg_r.timeout_us   <= TIMEOUT_US_RST;
      cfg_r.settle_us    <= SETTLE_US_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICKS_PER_US: cfg_r.ticks_per_us <= cfg_data[7:0];
        REG_PULSE_US:     cfg_r.pulse_us     <= cfg_data[7:0];
        REG_TIMEOUT_US:   cfg_r.timeout_us   <= cfg_data;
        REG_SETTLE_US:    cfg_r.settle_us    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  durs_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Sequencer state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // At most one trigger is driven at a time.
  a_trig_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(st_r.trig))
    else $error("both triggers driven");

  // A stopped counter always holds zero.
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.run |-> (st_r.cnt == '0))
    else $error("stopped counter not zero");

  // A completed pair leaves the first sensor selected.
  a_pair_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.pair_valid) |=> (st_r.sel == 1'b0))
    else $error("pair completed without returning to first sensor");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result item changed");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import durs_pkg::*;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed plan: either an input item or a register write.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DAT_W-1:0]   reg_data;
    durs_in_t               stim;
    bit                     pinned;
    durs_out_t              want;
  } plan_row_t;

  // Expected value typed in by hand for an item, when pinned is set.
  typedef struct packed {
    bit        pinned;
    durs_out_t want;
  } ranging_note_t;

  localparam durs_in_t IN_QUIET   = 3'b000;
  localparam durs_in_t IN_START   = 3'b100;
  localparam durs_in_t IN_ECHO_A  = 3'b010;
  localparam durs_in_t IN_ECHO_B  = 3'b001;
  localparam durs_in_t IN_ECHO_AB = 3'b011;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

  localparam durs_out_t NO_WANT = '0;
  localparam durs_out_t WANT_FIRST_FIRED = '{1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0};
  localparam durs_out_t WANT_BOTH_TIMEOUT = '{1'b0, 1'b0, 1'b0, 1'b1, RD_TIMEOUT, RD_TIMEOUT};

  localparam int PLAN_ROWS = 33;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Default timing: quiet tick, fire, echoes on both sensors, start in settle.
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b1, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_START,   1'b1, WANT_FIRST_FIRED},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_A,  1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_B,  1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_START,   1'b0, NO_WANT},
    // Shortest timing, then both sensors time out.
    '{ROW_CFG,  REG_TICKS_PER_US, 16'd1, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_CFG,  REG_PULSE_US,     16'd1, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_CFG,  REG_TIMEOUT_US,   16'd2, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_CFG,  REG_SETTLE_US,    16'd1, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b1, WANT_BOTH_TIMEOUT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_START,   1'b0, NO_WANT},
    // A zero tick scale makes every load expire on the next tick.
    '{ROW_CFG,  REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    // Writes to missing registers are dropped; wide data is cut to the register.
    '{ROW_CFG,  REG_UNUSED,       16'hFFFF, IN_QUIET, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_TOP,          16'h1234, IN_QUIET, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_TICKS_PER_US, 16'hFF02, IN_QUIET, 1'b0, NO_WANT},
    // The second echo rises while the first is being timed.
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_START,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_QUIET,   1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_A,  1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_AB, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_TICKS_PER_US, 16'd0, IN_ECHO_B,  1'b0, NO_WANT}
  };

  // Timing settings for the random part: ticks, pulse, timeout, settle.
  localparam int SETTINGS_N = 6;
  localparam int SET_TICKS   [SETTINGS_N] = '{1, 2, 1, 3, 255, 255};
  localparam int SET_PULSE   [SETTINGS_N] = '{1, 3, 5, 2, 1, 255};
  localparam int SET_TIMEOUT [SETTINGS_N] = '{1, 12, 25, 5, 2, 65535};
  localparam int SET_SETTLE  [SETTINGS_N] = '{1, 6, 10, 3, 1, 65535};

  localparam int IN_IDLE_PCT  [3] = '{31, 50, 0};
  localparam int OUT_IDLE_PCT [3] = '{50, 31, 0};

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  durs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  durs_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  durs_out_t expected_ranging [$];
  ranging_note_t pinned_notes [$];

  // Mirror of the sequencer state and its timing registers.
  durs_cfg_t ranger_cfg = '{TICKS_PER_US_RST, PULSE_US_RST, TIMEOUT_US_RST, SETTLE_US_RST};
  logic [2:0]  rng_phase = PH_IDLE;
  logic        rng_sel = 1'b0;
  logic [31:0] rng_count = '0;
  logic        rng_running = 1'b0;
  logic [1:0]  rng_echo = '0;
  logic [1:0]  rng_trig = '0;
  logic [31:0] rng_reading [2] = '{32'd0, 32'd0};

  dual_ultrasonic_ranger_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Counter load: ticks per microsecond times a microsecond setting.
  function automatic void arm_counter(input logic [15:0] us);
    rng_count = 32'(ranger_cfg.ticks_per_us) * 32'(us);
    rng_running = 1'b1;
  endfunction

  function automatic void pulse_trigger();
    rng_phase = PH_PULSE;
    rng_trig = rng_sel ? 2'b10 : 2'b01;
    arm_counter(16'(ranger_cfg.pulse_us));
  endfunction

  // Advance the mirror by one tick and return the output it shows.
  function automatic durs_out_t next_ranging(input durs_in_t d);
    logic [1:0] echo;
    logic expired;
    logic pair;
    durs_out_t r;
    echo = {d.echo_second, d.echo_first};
    expired = 1'b0;
    pair = 1'b0;
    if (rng_running) begin
      if (rng_count <= 32'd1) begin
        rng_count = '0;
        rng_running = 1'b0;
        expired = 1'b1;
      end else begin
        rng_count = rng_count - 32'd1;
      end
    end
    // An edge on either pin acts on the selected sensor and cancels an expiry.
    if (echo != rng_echo) begin
      if (echo[rng_sel]) begin
        rng_phase = PH_TIMING;
        arm_counter(ranger_cfg.timeout_us);
      end else begin
        rng_reading[rng_sel] = rng_count;
        rng_sel = ~rng_sel;
        if (!rng_sel) begin
          rng_phase = PH_SETTLE;
          pair = 1'b1;
        end else begin
          rng_phase = PH_SETTLE_FIRE;
        end
        arm_counter(ranger_cfg.settle_us);
      end
      expired = 1'b0;
    end
    rng_echo = echo;
    if (expired) begin
      case (rng_phase)
        PH_PULSE: begin
          rng_phase = PH_WAIT;
          rng_trig = 2'b00;
          arm_counter(ranger_cfg.timeout_us);
        end
        PH_SETTLE: rng_phase = PH_IDLE;
        PH_SETTLE_FIRE: pulse_trigger();
        default: begin
          rng_reading[rng_sel] = RD_TIMEOUT;
          rng_sel = ~rng_sel;
          rng_phase = PH_IDLE;
          if (!rng_sel) pair = 1'b1;
          else pulse_trigger();
        end
      endcase
    end
    if (d.start_request) begin
      if (rng_phase == PH_IDLE) pulse_trigger();
      else if (rng_phase == PH_SETTLE) rng_phase = PH_SETTLE_FIRE;
    end
    r.trigger_first = rng_trig[0];
    r.trigger_second = rng_trig[1];
    r.busy_res = !(rng_phase == PH_IDLE || rng_phase == PH_SETTLE);
    r.pair_valid = pair;
    r.reading_first = rng_reading[0];
    r.reading_second = rng_reading[1];
    return r;
  endfunction

  task automatic compare_ranging(input durs_out_t want, input durs_out_t got);
    if (got.trigger_first !== want.trigger_first) begin
      $error("trigger_first: expected %0d, got %0d", want.trigger_first, got.trigger_first);
      errors++;
    end
    if (got.trigger_second !== want.trigger_second) begin
      $error("trigger_second: expected %0d, got %0d", want.trigger_second, got.trigger_second);
      errors++;
    end
    if (got.busy_res !== want.busy_res) begin
      $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
      errors++;
    end
    if (got.pair_valid !== want.pair_valid) begin
      $error("pair_valid: expected %0d, got %0d", want.pair_valid, got.pair_valid);
      errors++;
    end
    if (got.reading_first !== want.reading_first) begin
      $error("reading_first: expected %0h, got %0h", want.reading_first, got.reading_first);
      errors++;
    end
    if (got.reading_second !== want.reading_second) begin
      $error("reading_second: expected %0h, got %0h", want.reading_second, got.reading_second);
      errors++;
    end
  endtask

  // Check result items and track accepted input items and register writes.
  always @(posedge clk) begin : scoreboard
    ranging_note_t note;
    durs_out_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ranging.size() == 0) begin
          $error("result item with none expected: %h", out_data);
          errors++;
        end else begin
          compare_ranging(expected_ranging.pop_front(), out_data);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICKS_PER_US: ranger_cfg.ticks_per_us = cfg_data[7:0];
          REG_PULSE_US:     ranger_cfg.pulse_us = cfg_data[7:0];
          REG_TIMEOUT_US:   ranger_cfg.timeout_us = cfg_data;
          REG_SETTLE_US:    ranger_cfg.settle_us = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        note = pinned_notes.pop_front();
        predicted = next_ranging(in_data);
        expected_ranging.push_back(note.pinned ? note.want : predicted);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when asked.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input durs_in_t d, input bit pin, input durs_out_t want);
    ranging_note_t note;
    note.pinned = pin;
    note.want = want;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_notes.push_back(note);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering items and wait until every expected result item is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ranging.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic int clip(input int x);
    return (x > 40) ? 40 : x;
  endfunction

  // Quiet tick with an occasional stray start request.
  function automatic durs_in_t quiet_item();
    return ($urandom_range(0, 19) == 0) ? IN_START : IN_QUIET;
  endfunction

  initial begin : stimulus
    int pl;
    int tl;
    int sl;
    int n;
    int sent;
    int quota;
    durs_in_t burst [$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        wait_for_results();
        write_reg(PLAN[r].reg_index, PLAN[r].reg_data);
        cfg_valid <= 1'b0;
      end else begin
        send_item(PLAN[r].stim, PLAN[r].pinned, PLAN[r].want);
      end
    end

    // Random part: three idling modes, each across all timing settings.
    for (int m = 0; m < 3; m++) begin
      in_idle_pct = IN_IDLE_PCT[m];
      out_idle_pct = OUT_IDLE_PCT[m];
      for (int s = 0; s < SETTINGS_N; s++) begin
        wait_for_results();
        write_reg(REG_TICKS_PER_US, 16'(SET_TICKS[s]));
        write_reg(REG_PULSE_US, 16'(SET_PULSE[s]));
        write_reg(REG_TIMEOUT_US, 16'(SET_TIMEOUT[s]));
        write_reg(REG_SETTLE_US, 16'(SET_SETTLE[s]));
        cfg_valid <= 1'b0;
        if (s == 1) hold_off_req = 1'b1;
        pl = clip(SET_TICKS[s] * SET_PULSE[s]);
        tl = clip(SET_TICKS[s] * SET_TIMEOUT[s]);
        sl = clip(SET_TICKS[s] * SET_SETTLE[s]);
        quota = (s == SETTINGS_N - 1) ? 30 : 85;
        sent = 0;
        burst.delete();
        while (sent < quota) begin
          if (burst.size() == 0) begin
            if ($urandom_range(0, 99) < 80) begin
              // Measurement: start, then an echo from each sensor in turn,
              // each one sometimes missing or longer than the timeout.
              burst.push_back(IN_START);
              n = $urandom_range(0, pl + tl + 1);
              repeat (n) burst.push_back(quiet_item());
              if ($urandom_range(0, 6) != 0) begin
                n = $urandom_range(1, tl + 1);
                repeat (n) burst.push_back(IN_ECHO_A);
              end
              n = $urandom_range(0, sl + pl + tl + 1);
              repeat (n) burst.push_back(quiet_item());
              if ($urandom_range(0, 6) != 0) begin
                n = $urandom_range(1, tl + 1);
                repeat (n) burst.push_back(IN_ECHO_B);
              end
              n = $urandom_range(0, sl + 2);
              repeat (n) burst.push_back(quiet_item());
            end else begin
              n = $urandom_range(1, 20);
              repeat (n) burst.push_back(durs_in_t'(3'($urandom_range(0, 7))));
            end
          end
          send_item(burst.pop_front(), 1'b0, NO_WANT);
          sent++;
        end
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (errors == 0 && expected_ranging.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- dual_ultrasonic_ranger_sequencer.f -----
src/durs_pkg.sv
src/durs_step.sv
src/dual_ultrasonic_ranger_sequencer.sv
verif/testbench.sv
